>>> rtl/core/wdtr_pkg.sv
`default_nettype none

package wdtr_pkg;

  // Sizes fixed by the message and reply formats
  localparam int WORKER_SLOTS_DEF = 16;
  localparam int ITEM_LIMIT       = 65536;
  localparam int CFG_AW           = 4;
  localparam int CNT_W            = 17;
  localparam int ITEM_W           = 16;
  localparam int WID_W            = 4;
  localparam int TICK_W           = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [CNT_W-1:0]  TOTAL_RST   = '0;
  localparam logic [WID_W-1:0]  WCOUNT_RST  = 4'd1;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd150;
  localparam logic [3:0]        EXIT_MAX    = 4'd15;

  // Reply codes
  typedef enum logic [1:0] {
    KIND_TAKE  = 2'd0,
    KIND_SLEEP = 2'd1,
    KIND_EXIT  = 2'd2
  } reply_kind_t;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_TOTAL   = 2'd0,
    REG_WCOUNT  = 2'd1,
    REG_TIMEOUT = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_SCAN = 2'd2,
    ST_PUSH = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;   // latch incoming request
    logic eval;  // apply report, pick grant / scan / exit
    logic scan;  // walk one slot
    logic push;  // load reply into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reply;     // reply known at evaluation
    logic scan;      // timeout scan needed
    logic hit;       // stale slot found this cycle
    logic done;      // scan finished, nothing stale
    logic out_free;  // output register can take a reply
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/wdtr_ram.sv
`default_nettype none

module wdtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/wdtr_ctrl.sv
`default_nettype none

module wdtr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wdtr_pkg::dp_stat_t stat,
  output wdtr_pkg::dp_cmd_t  cmd
);

  wdtr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdtr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wdtr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = wdtr_pkg::ST_EVAL;
      end
      wdtr_pkg::ST_EVAL: begin
        if (stat.reply)     state_nxt = wdtr_pkg::ST_PUSH;
        else if (stat.scan) state_nxt = wdtr_pkg::ST_SCAN;
        else                state_nxt = wdtr_pkg::ST_IDLE;
      end
      wdtr_pkg::ST_SCAN: begin
        if (stat.hit || stat.done) state_nxt = wdtr_pkg::ST_PUSH;
      end
      wdtr_pkg::ST_PUSH: begin
        if (stat.out_free) state_nxt = wdtr_pkg::ST_IDLE;
      end
      default: state_nxt = wdtr_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      wdtr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      wdtr_pkg::ST_EVAL: cmd.eval = 1'b1;
      wdtr_pkg::ST_SCAN: cmd.scan = 1'b1;
      wdtr_pkg::ST_PUSH: cmd.push = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/wdtr_dpath.sv
`default_nettype none

module wdtr_dpath #(
  parameter int WORKER_SLOTS = wdtr_pkg::WORKER_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wdtr_pkg::dp_cmd_t                cmd,
  output wdtr_pkg::dp_stat_t               stat,
  // request
  input  logic                             in_opcode,
  input  logic [wdtr_pkg::WID_W-1:0]       in_worker_id,
  input  logic [wdtr_pkg::TICK_W-1:0]      in_now_ticks,
  // reply
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [1:0]                       out_reply_kind,
  output logic [wdtr_pkg::ITEM_W-1:0]      out_item_index,
  output logic [wdtr_pkg::WID_W-1:0]       out_dest_worker,
  output logic                             out_any_failure,
  output logic                             out_all_exited,
  // register access
  input  logic                             cfg_wr,
  input  logic [wdtr_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata
);

  localparam int AW = $clog2(WORKER_SLOTS);
  localparam int SW = wdtr_pkg::ITEM_W + wdtr_pkg::TICK_W;

  // Configuration
  logic [wdtr_pkg::CNT_W-1:0]  total_r;
  logic [wdtr_pkg::WID_W-1:0]  wcount_r;
  logic [wdtr_pkg::TICK_W-1:0] timeout_r;

  // Progress
  logic [wdtr_pkg::CNT_W-1:0]  next_r, fin_r, fin_new;
  logic [3:0]                  exit_r;
  logic                        fail_r;
  logic [WORKER_SLOTS-1:0]     busy_r, busy_nxt;

  // Latched request
  logic                        op_r;
  logic [wdtr_pkg::WID_W-1:0]  wid_r;
  logic [wdtr_pkg::TICK_W-1:0] now_r;

  // Pending reply
  wdtr_pkg::reply_kind_t       kind_r;
  logic [wdtr_pkg::ITEM_W-1:0] item_r;

  // Scan pointers
  logic [wdtr_pkg::WID_W-1:0]  rd_ptr_r, chk_ptr_r, last;
  logic                        chk_vld_r;

  // Output register
  logic                        out_valid_r;
  logic [1:0]                  out_kind_r;
  logic [wdtr_pkg::ITEM_W-1:0] out_item_r;
  logic [wdtr_pkg::WID_W-1:0]  out_dest_r;
  logic                        out_fail_r, out_exited_r;

  // Slot table
  logic                        has_slot, slot_we;
  logic [AW-1:0]               wslot, cslot;
  logic [SW-1:0]               slot_wdata, slot_rdata;
  logic [wdtr_pkg::ITEM_W-1:0] rd_item;
  logic [wdtr_pkg::TICK_W-1:0] rd_stamp, age;

  logic grant_c, scan_c, exit_c, hit_c, done_c;
  logic [wdtr_pkg::CNT_W-1:0] total_in;

  assign has_slot = 32'(wid_r) < WORKER_SLOTS;
  assign wslot    = AW'(wid_r);
  assign cslot    = AW'(chk_ptr_r);
  assign rd_item  = slot_rdata[SW-1 -: wdtr_pkg::ITEM_W];
  assign rd_stamp = slot_rdata[wdtr_pkg::TICK_W-1:0];
  assign age      = now_r - rd_stamp;

  // Highest worker scanned
  always_comb begin
    if (32'(wcount_r) > WORKER_SLOTS - 1) last = wdtr_pkg::WID_W'(WORKER_SLOTS - 1);
    else                                  last = wcount_r;
  end

  // Report first, then decide
  assign fin_new = (op_r && fin_r != wdtr_pkg::CNT_MAX) ? fin_r + 1'b1 : fin_r;
  assign grant_c = next_r < total_r;
  assign scan_c  = !grant_c && (fin_new < total_r) && (next_r == total_r);
  assign exit_c  = !grant_c && !scan_c && (fin_new == total_r);

  // Slot check against data read last cycle
  assign hit_c  = cmd.scan && chk_vld_r && busy_r[cslot] && (age > timeout_r);
  assign done_c = cmd.scan && chk_vld_r && !hit_c && (chk_ptr_r == last);

  always_comb begin
    stat          = '0;
    stat.reply    = grant_c || exit_c || (scan_c && last == '0);
    stat.scan     = scan_c && last != '0;
    stat.hit      = hit_c;
    stat.done     = done_c;
    stat.out_free = !out_valid_r || !out_stall;
  end

  // Slot write on grant or reassignment
  assign slot_we    = has_slot && ((cmd.eval && grant_c) || hit_c);
  assign slot_wdata = {(hit_c ? rd_item : next_r[wdtr_pkg::ITEM_W-1:0]), now_r};

  wdtr_ram #(
    .WIDTH (SW),
    .DEPTH (WORKER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (wslot),
    .wdata (slot_wdata),
    .raddr (AW'(rd_ptr_r)),
    .rdata (slot_rdata)
  );

  // Busy bits: clear on report and on take-back, set on write
  always_comb begin
    busy_nxt = busy_r;
    if (cmd.eval && op_r && has_slot) busy_nxt[wslot] = 1'b0;
    if (hit_c)                        busy_nxt[cslot] = 1'b0;
    if (slot_we)                      busy_nxt[wslot] = 1'b1;
  end

  // Configuration writes, total clamped to the item limit
  assign total_in = pwdata[wdtr_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= wdtr_pkg::TOTAL_RST;
      wcount_r  <= wdtr_pkg::WCOUNT_RST;
      timeout_r <= wdtr_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (wdtr_pkg::cfg_reg_t'(paddr[3:2]))
        wdtr_pkg::REG_TOTAL: begin
          if (32'(total_in) > 32'(wdtr_pkg::ITEM_LIMIT))
            total_r <= wdtr_pkg::CNT_W'(wdtr_pkg::ITEM_LIMIT);
          else
            total_r <= total_in;
        end
        wdtr_pkg::REG_WCOUNT:  wcount_r  <= pwdata[wdtr_pkg::WID_W-1:0];
        wdtr_pkg::REG_TIMEOUT: timeout_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (wdtr_pkg::cfg_reg_t'(paddr[3:2]))
      wdtr_pkg::REG_TOTAL:   prdata = 32'(total_r);
      wdtr_pkg::REG_WCOUNT:  prdata = 32'(wcount_r);
      wdtr_pkg::REG_TIMEOUT: prdata = timeout_r;
      default:               prdata = '0;
    endcase
  end

  // Dispatch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r    <= '0;
      fin_r     <= '0;
      exit_r    <= '0;
      fail_r    <= 1'b0;
      busy_r    <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (cmd.eval) begin
        fin_r     <= fin_new;
        rd_ptr_r  <= wdtr_pkg::WID_W'(1);
        chk_vld_r <= 1'b0;
        if (grant_c) next_r <= next_r + 1'b1;
        if (exit_c && exit_r != wdtr_pkg::EXIT_MAX) exit_r <= exit_r + 1'b1;
      end
      if (cmd.scan) begin
        chk_ptr_r <= rd_ptr_r;
        chk_vld_r <= rd_ptr_r <= last;
        rd_ptr_r  <= rd_ptr_r + 1'b1;
      end
      if (hit_c) fail_r <= 1'b1;
    end
  end

  // Request latch and pending reply
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_opcode;
      wid_r <= in_worker_id;
      now_r <= in_now_ticks;
    end
    if (cmd.eval) begin
      if (grant_c) begin
        kind_r <= wdtr_pkg::KIND_TAKE;
        item_r <= next_r[wdtr_pkg::ITEM_W-1:0];
      end else if (exit_c) begin
        kind_r <= wdtr_pkg::KIND_EXIT;
        item_r <= '0;
      end else begin
        kind_r <= wdtr_pkg::KIND_SLEEP;
        item_r <= '0;
      end
    end else if (hit_c) begin
      kind_r <= wdtr_pkg::KIND_TAKE;
      item_r <= rd_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind_r   <= kind_r;
      out_item_r   <= item_r;
      out_dest_r   <= wid_r;
      out_fail_r   <= fail_r;
      out_exited_r <= exit_r >= wcount_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_item_index  = out_item_r;
  assign out_dest_worker = out_dest_r;
  assign out_any_failure = out_fail_r;
  assign out_all_exited  = out_exited_r;

endmodule

`default_nettype wire

>>> rtl/core/work_dispatcher_with_timeout_reassign_core.sv
`default_nettype none

// Work dispatcher: each request is a worker asking for work or reporting
// its item finished; the reply grants the next item, hands over a timed-out
// item, says sleep or says exit. One request is handled at a time. A grant
// or exit reply passes from evaluation to the push state and into the output
// register, waiting in push while the output still holds a stalled reply;
// the next request is taken once it is loaded. A sleep or take-back reply
// walks the slot table one worker per cycle through its single read port,
// checking workers 1 to worker_count, at most WORKER_SLOTS-1. A report
// that draws no reply frees the input after evaluation. A held reply at the
// output does not block the next request, only the next reply.
module work_dispatcher_with_timeout_reassign_core #(
  parameter int WORKER_SLOTS = wdtr_pkg::WORKER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [wdtr_pkg::WID_W-1:0]  in_worker_id,
  input  logic [wdtr_pkg::TICK_W-1:0] in_now_ticks,
  // reply channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_reply_kind,
  output logic [wdtr_pkg::ITEM_W-1:0] out_item_index,
  output logic [wdtr_pkg::WID_W-1:0]  out_dest_worker,
  output logic                        out_any_failure,
  output logic                        out_all_exited,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wdtr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  wdtr_pkg::dp_cmd_t  cmd;
  wdtr_pkg::dp_stat_t stat;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  wdtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wdtr_dpath #(
    .WORKER_SLOTS (WORKER_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_worker_id    (in_worker_id),
    .in_now_ticks    (in_now_ticks),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_reply_kind  (out_reply_kind),
    .out_item_index  (out_item_index),
    .out_dest_worker (out_dest_worker),
    .out_any_failure (out_any_failure),
    .out_all_exited  (out_all_exited),
    .cfg_wr          (cfg_wr),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/wdtr_checker.sv
`default_nettype none

module wdtr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_reply_kind,
  input logic [wdtr_pkg::ITEM_W-1:0] out_item_index,
  input logic [wdtr_pkg::WID_W-1:0]  out_dest_worker
);

  // A taken request keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in progress");

  // Held reply stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_kind)
      && $stable(out_item_index) && $stable(out_dest_worker))
    else $error("stalled reply changed");

  // Sleep and exit carry no item
  a_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind != wdtr_pkg::KIND_TAKE |-> out_item_index == '0)
    else $error("item index on a non-grant reply");

  // Reset leaves no reply pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake state");

endmodule

bind work_dispatcher_with_timeout_reassign_core wdtr_checker u_wdtr_checker (.*);

`default_nettype wire
